FILE: rtl/phc_pkg.sv
// Shared constants and types for the peer connect holdoff table.
package phc_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned MS_W   = 32;
  localparam int unsigned KEY_W  = MAC_W + IP_W + PORT_W;

  localparam int unsigned HOLDOFF_RESET_SEC = 2;
  localparam logic [MS_W-1:0] HOLDOFF_RESET = MS_W'(HOLDOFF_RESET_SEC * 1000);

  typedef enum logic [1:0] {
    OUT_CONNECT  = 2'd0,
    OUT_SUPPRESS = 2'd1,
    OUT_FULL     = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } peer_key_t;

  // Write request towards the table store
  typedef struct packed {
    logic             key_we;
    logic             stamp_we;
    logic [IDX_W-1:0] addr;
    peer_key_t        key;
    logic [MS_W-1:0]  stamp;
  } store_wr_t;

endpackage

FILE: rtl/phc_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
interface phc_req_if;
  logic                     valid;
  logic                     ready;
  logic [phc_pkg::MAC_W-1:0]  peer_mac;
  logic [phc_pkg::IP_W-1:0]   peer_ip;
  logic [phc_pkg::PORT_W-1:0] peer_port;
  logic [phc_pkg::MS_W-1:0]   now_ms;

  modport source (output valid, peer_mac, peer_ip, peer_port, now_ms, input ready);
  modport sink   (input valid, peer_mac, peer_ip, peer_port, now_ms, output ready);
endinterface

interface phc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic       was_known;

  modport source (output valid, outcome, was_known, input ready);
  modport sink   (input valid, outcome, was_known, output ready);
endinterface

interface phc_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [phc_pkg::MS_W-1:0] holdoff_ms;

  modport source (output valid, holdoff_ms, input ready);
  modport sink   (input valid, holdoff_ms, output ready);
endinterface

FILE: rtl/phc_store.sv
// Key and attempt-time memories: one write port, one registered read port.
module phc_store (
  input  logic                          clk_i,
  input  phc_pkg::store_wr_t            wr_i,
  input  logic [phc_pkg::IDX_W-1:0]     rd_addr_i,
  output phc_pkg::peer_key_t            rd_key_o,
  output logic [phc_pkg::MS_W-1:0]      rd_stamp_o
);

  phc_pkg::peer_key_t        key_mem   [phc_pkg::TABLE_ENTRIES];
  logic [phc_pkg::MS_W-1:0]  stamp_mem [phc_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem[wr_i.addr] <= wr_i.key;
    end
    rd_key_o <= key_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.stamp_we) begin
      stamp_mem[wr_i.addr] <= wr_i.stamp;
    end
    rd_stamp_o <= stamp_mem[rd_addr_i];
  end

endmodule

FILE: rtl/peer_connect_holdoff_table_unit.sv
// Peer connect holdoff table: top level with search sequencer and result register.
//
//   channel  dir  payload                               accepted when
//   req_i    in   peer_mac, peer_ip, peer_port, now_ms  valid & ready
//   rsp_o    out  outcome, was_known                    valid & ready
//   cfg_i    in   holdoff_ms                            valid & ready (ready always high)
//
// One item at a time. A miss passes through the scan of every stored key, then
// the miss and finish states, before its result enters the output register;
// the key memory is scanned one entry per cycle via its single read port.
// A known key ends the scan early, at the entry that holds it.
// Reset empties the table at once (entry count to zero), no clearing pass.
// A stalled result holds the sequencer in its final state until the output
// register is free; the next item is taken from the cycle after the load.
module peer_connect_holdoff_table_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  phc_req_if.sink      req_i,
  phc_rsp_if.source    rsp_o,
  phc_cfg_if.sink      cfg_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_FINISH
  } state_e;

  state_e                           state_q, state_d;
  logic [phc_pkg::IDX_W-1:0]        idx_q, idx_d;
  logic [phc_pkg::CNT_W-1:0]        count_q, count_d;
  logic [phc_pkg::MS_W-1:0]         holdoff_q;
  phc_pkg::peer_key_t               key_q;
  logic [phc_pkg::MS_W-1:0]         now_q;
  logic [1:0]                       res_outcome_q, res_outcome_d;
  logic                             res_known_q, res_known_d;
  logic                             out_valid_q;
  logic [1:0]                       out_outcome_q;
  logic                             out_known_q;

  phc_pkg::store_wr_t               wr;
  logic [phc_pkg::IDX_W-1:0]        rd_addr;
  phc_pkg::peer_key_t               rd_key;
  logic [phc_pkg::MS_W-1:0]         rd_stamp;
  logic [phc_pkg::MS_W-1:0]         elapsed;
  logic                             hit;
  logic                             last;
  logic                             req_fire;
  logic                             out_free;

  phc_store u_store (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_addr_i  (rd_addr),
    .rd_key_o   (rd_key),
    .rd_stamp_o (rd_stamp)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.outcome   = out_outcome_q;
  assign rsp_o.was_known = out_known_q;
  assign out_free        = !out_valid_q || rsp_o.ready;

  // Next entry is fetched while the current one is compared
  assign rd_addr = (state_q == ST_SCAN) ? idx_q + 1'b1 : '0;
  assign hit     = (rd_key == key_q);
  assign last    = (({1'b0, idx_q} + phc_pkg::CNT_W'(1)) == count_q);
  assign elapsed = now_q - rd_stamp;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    count_d       = count_q;
    res_outcome_d = res_outcome_q;
    res_known_d   = res_known_q;
    wr            = '0;
    wr.key        = key_q;
    wr.stamp      = now_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          idx_d   = '0;
          state_d = (count_q == '0) ? ST_MISS : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_known_d = 1'b1;
          if (elapsed > holdoff_q) begin
            wr.stamp_we   = 1'b1;
            wr.addr       = idx_q;
            res_outcome_d = phc_pkg::OUT_CONNECT;
          end else begin
            res_outcome_d = phc_pkg::OUT_SUPPRESS;
          end
          state_d = ST_FINISH;
        end else if (last) begin
          state_d = ST_MISS;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_MISS: begin
        res_known_d = 1'b0;
        if (count_q == phc_pkg::CNT_W'(phc_pkg::TABLE_ENTRIES)) begin
          res_outcome_d = phc_pkg::OUT_FULL;
        end else begin
          wr.key_we     = 1'b1;
          wr.stamp_we   = 1'b1;
          wr.addr       = count_q[phc_pkg::IDX_W-1:0];
          count_d       = count_q + 1'b1;
          res_outcome_d = phc_pkg::OUT_CONNECT;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      count_q       <= '0;
      holdoff_q     <= phc_pkg::HOLDOFF_RESET;
      out_valid_q   <= 1'b0;
      out_outcome_q <= phc_pkg::OUT_CONNECT;
      out_known_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      if (cfg_i.valid && cfg_i.ready) begin
        holdoff_q <= cfg_i.holdoff_ms;
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q   <= 1'b1;
        out_outcome_q <= res_outcome_q;
        out_known_q   <= res_known_q;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      key_q.mac  <= req_i.peer_mac;
      key_q.ip   <= req_i.peer_ip;
      key_q.port <= req_i.peer_port;
      now_q      <= req_i.now_ms;
    end
    res_outcome_q <= res_outcome_d;
    res_known_q   <= res_known_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= phc_pkg::CNT_W'(phc_pkg::TABLE_ENTRIES))
    else $error("entry count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MISS && count_q != phc_pkg::CNT_W'(phc_pkg::TABLE_ENTRIES))
    |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the table by one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MISS) |=> count_q == $past(count_q))
    else $error("entry count changed outside an insert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_outcome_q == phc_pkg::OUT_FULL) |-> !out_known_q)
    else $error("full result flagged as known key");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside the finish state");

endmodule

FILE: verif/tb_peer_connect_holdoff_table_unit.sv
// Testbench for the peer connect holdoff table: directed holdoff cases, then random traffic.
module tb_peer_connect_holdoff_table_unit;

  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned DRAIN_CYCLES    = 2 * (phc_pkg::TABLE_ENTRIES + 3);
  localparam int unsigned CFG_SETTLE      = 4;
  localparam int unsigned ITEMS_PER_PHASE = 223;

  typedef struct {
    phc_pkg::outcome_e outcome;
    logic              was_known;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  phc_req_if req_if ();
  phc_rsp_if rsp_if ();
  phc_cfg_if cfg_if ();

  peer_connect_holdoff_table_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Shadow of the table and of the holdoff register
  phc_pkg::peer_key_t       known_peers[$];
  logic [phc_pkg::MS_W-1:0] peer_stamps[$];
  logic [phc_pkg::MS_W-1:0] holdoff_shadow;
  verdict_t                 pending_verdicts[$];

  int unsigned req_idle_pct  = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned fail_count    = 0;
  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned connect_seen  = 0;
  int unsigned suppress_seen = 0;
  int unsigned full_seen     = 0;
  int unsigned cfg_writes    = 0;
  logic [phc_pkg::MS_W-1:0] wall_ms;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Works out the verdict for one accepted request and updates the shadow table
  function automatic void judge_request(input phc_pkg::peer_key_t key,
                                        input logic [phc_pkg::MS_W-1:0] now);
    verdict_t                 v;
    int                       hit;
    logic [phc_pkg::MS_W-1:0] elapsed;
    hit = -1;
    foreach (known_peers[i])
      if (hit < 0 && known_peers[i] == key) hit = i;
    if (hit >= 0) begin
      v.was_known = 1'b1;
      elapsed = now - peer_stamps[hit];
      if (elapsed > holdoff_shadow) begin
        peer_stamps[hit] = now;
        v.outcome = phc_pkg::OUT_CONNECT;
      end else begin
        v.outcome = phc_pkg::OUT_SUPPRESS;
      end
    end else begin
      v.was_known = 1'b0;
      if (known_peers.size() >= phc_pkg::TABLE_ENTRIES) begin
        v.outcome = phc_pkg::OUT_FULL;
      end else begin
        known_peers.push_back(key);
        peer_stamps.push_back(now);
        v.outcome = phc_pkg::OUT_CONNECT;
      end
    end
    pending_verdicts.push_back(v);
  endfunction

  function automatic phc_pkg::peer_key_t fresh_key();
    phc_pkg::peer_key_t k;
    k = {$urandom, $urandom, $urandom};
    return k;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // valid is low on entry and is left low after acceptance
  task automatic send_request(input phc_pkg::peer_key_t key,
                              input logic [phc_pkg::MS_W-1:0] now);
    while ($urandom_range(99, 0) < req_idle_pct) @(posedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.peer_mac  <= key.mac;
    req_if.peer_ip   <= key.ip;
    req_if.peer_port <= key.port;
    req_if.now_ms    <= now;
    do @(posedge clk_i); while (!req_if.ready);
    judge_request(key, now);
    sent_count++;
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_holdoff(input logic [phc_pkg::MS_W-1:0] value);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.holdoff_ms <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    holdoff_shadow = value;
    cfg_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reset value of the register; exact boundary and wrap of the elapsed time
  task automatic test_default_holdoff();
    phc_pkg::peer_key_t k_zero;
    phc_pkg::peer_key_t k_ones;
    phc_pkg::peer_key_t k_near;
    k_zero = '0;
    k_ones = '1;
    send_request(k_zero, 32'd0);
    send_request(k_zero, 32'd2000);
    send_request(k_zero, 32'd2001);
    send_request(k_ones, 32'hFFFF_FFFF);
    send_request(k_ones, 32'h0000_07CF);
    send_request(k_ones, 32'h0000_07D0);
    // keys one field away from a stored one must not match
    k_near = k_zero;
    k_near.ip = 32'd1;
    send_request(k_near, 32'd10);
    k_near = k_zero;
    k_near.port = 16'd1;
    send_request(k_near, 32'd10);
    k_near = k_zero;
    k_near.mac[phc_pkg::MAC_W-1] = 1'b1;
    send_request(k_near, 32'd10);
  endtask

  task automatic test_zero_holdoff();
    phc_pkg::peer_key_t k_zero;
    phc_pkg::peer_key_t k_ones;
    k_zero = '0;
    k_ones = '1;
    write_holdoff('0);
    send_request(k_zero, 32'd2001);
    send_request(k_zero, 32'd2002);
    send_request(k_ones, 32'h0000_07CF);
  endtask

  // A known key never reconnects with the largest holdoff
  task automatic test_max_holdoff();
    phc_pkg::peer_key_t k_zero;
    k_zero = '0;
    write_holdoff('1);
    send_request(k_zero, 32'd2001);
    send_request(k_zero, 32'd2001);
    send_request(fresh_key(), $urandom);
  endtask

  task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [phc_pkg::MS_W-1:0] holdoff);
    phc_pkg::peer_key_t        key;
    logic [phc_pkg::MS_W-1:0]  now;
    logic [phc_pkg::MS_W-1:0]  step;
    logic [phc_pkg::KEY_W-1:0] bits;
    int unsigned               pick;
    int unsigned               slot;
    write_holdoff(holdoff);
    req_idle_pct  = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (items) begin
      pick = $urandom_range(99, 0);
      slot = (known_peers.size() != 0) ? $urandom_range(known_peers.size() - 1, 0) : 0;
      step = $urandom_range(120, 0);
      now  = wall_ms + step;
      if (pick < 70 && known_peers.size() != 0) begin
        key = known_peers[slot];
        case ($urandom_range(9, 0))
          0, 1, 2: now = peer_stamps[slot] + holdoff_shadow - 1 + $urandom_range(2, 0);
          3:       now = $urandom;
          default: ;
        endcase
      end else if (pick < 85 || known_peers.size() == 0) begin
        key = fresh_key();
        if ($urandom_range(9, 0) == 0) now = $urandom;
      end else begin
        // one bit away from a stored key
        bits = known_peers[slot];
        bits[$urandom_range(phc_pkg::KEY_W - 1, 0)] ^= 1'b1;
        key = bits;
      end
      wall_ms = now;
      send_request(key, now);
    end
  endtask

  // Result checker and receiver stalls
  initial begin
    verdict_t want;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: outcome %0d was_known %0b",
                                    rsp_if.outcome, rsp_if.was_known));
        end else begin
          want = pending_verdicts.pop_front();
          checked_count++;
          if (rsp_if.outcome !== want.outcome)
            report_mismatch($sformatf("result %0d outcome %0d, want %s", checked_count,
                                      rsp_if.outcome, want.outcome.name()));
          if (rsp_if.was_known !== want.was_known)
            report_mismatch($sformatf("result %0d was_known %0b, want %0b", checked_count,
                                      rsp_if.was_known, want.was_known));
          case (want.outcome)
            phc_pkg::OUT_CONNECT:  connect_seen++;
            phc_pkg::OUT_SUPPRESS: suppress_seen++;
            default:               full_seen++;
          endcase
        end
      end
      rsp_if.ready <= rst_ni && ($urandom_range(99, 0) >= rsp_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake on any channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results pending",
             IDLE_LIMIT, pending_verdicts.size());
    $display("tb_peer_connect_holdoff_table_unit: FAIL");
    $finish;
  end

  initial begin
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.peer_mac   <= '0;
    req_if.peer_ip    <= '0;
    req_if.peer_port  <= '0;
    req_if.now_ms     <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.holdoff_ms <= '0;
    holdoff_shadow = phc_pkg::HOLDOFF_RESET;
    wall_ms        = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_holdoff();
    test_zero_holdoff();
    test_max_holdoff();
    test_random_traffic(ITEMS_PER_PHASE, 0, 0, 32'd50);
    test_random_traffic(ITEMS_PER_PHASE, 64, 0, 32'd0);
    test_random_traffic(ITEMS_PER_PHASE, 0, 64, $urandom_range(300, 1));
    test_random_traffic(ITEMS_PER_PHASE, 29, 29, '1);
    test_random_traffic(ITEMS_PER_PHASE, 0, 0, $urandom);
    test_random_traffic(ITEMS_PER_PHASE, 29, 29, 32'd1000);

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked: %0d connect, %0d suppressed, %0d full",
             sent_count, checked_count, connect_seen, suppress_seen, full_seen);
    $display("%0d holdoff settings written, %0d peers stored at the end, %0d mismatches",
             cfg_writes, known_peers.size(), fail_count);
    if (fail_count == 0) begin
      $display("tb_peer_connect_holdoff_table_unit: PASS");
    end else begin
      $display("tb_peer_connect_holdoff_table_unit: FAIL");
    end
    $finish;
  end

endmodule
